// ----- rtl/mtbc_pkg.sv -----
// Package: constants, types and codes shared by the tag balance checker.
`timescale 1ns / 1ps
`default_nettype none

package mtbc_pkg;

    // Sizing
    localparam int STACK_DEPTH  = 64;
    localparam int MAX_NAME_LEN = 10;
    localparam int NAME_BITS    = 5 * MAX_NAME_LEN;
    localparam int LEN_W        = $clog2(MAX_NAME_LEN + 2);
    localparam int ENTRY_W      = NAME_BITS + LEN_W;
    localparam int LINE_W       = 24;
    localparam int STATUS_W     = 3;
    localparam int CHAR_W       = 8;
    localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int RAM_W        = ENTRY_W + LINE_W;
    localparam int OUT_W        = ((STATUS_W + LINE_W + 7) / 8) * 8;

    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
    localparam logic [LINE_W-1:0] LINE_ONE = LINE_W'(1);
    localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_NAME_LEN);
    localparam logic [LEN_W-1:0]  LEN_OVER = LEN_W'(MAX_NAME_LEN + 1);

    // Characters
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STRAY      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNCLOSED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LENGTH     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CHAR       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNBALANCED = 3'd5;
    localparam logic [STATUS_W-1:0] ST_COMMENT    = 3'd6;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd7;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_TAG_START,
        MODE_OPEN,
        MODE_CLOSE,
        MODE_COMMENT,
        MODE_DRAIN
    } mode_t;

    // Parser -> stack
    typedef struct packed {
        logic               clear;
        logic               push;
        logic               pop;
        logic [ENTRY_W-1:0] entry;
        logic [LINE_W-1:0]  line;
    } stack_cmd_t;

    // Stack -> parser
    typedef struct packed {
        logic               empty;
        logic               full;
        logic [ENTRY_W-1:0] entry;
        logic [LINE_W-1:0]  line;
    } stack_top_t;

    // Parser -> output buffer
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [LINE_W-1:0]   line;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/mtbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mtbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mtbc_stack.sv -----
// Tag stack: top entry in registers, deeper entries in a RAM, refetch on pop.
`timescale 1ns / 1ps
`default_nettype none

module mtbc_stack (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mtbc_pkg::stack_cmd_t cmd,
    output mtbc_pkg::stack_top_t     top
);

    logic [mtbc_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [mtbc_pkg::ENTRY_W-1:0] top_entry_reg, top_entry_next;
    logic [mtbc_pkg::LINE_W-1:0]  top_line_reg, top_line_next;
    logic                         pending_reg, pending_next;

    logic                         ram_we, ram_re;
    logic [mtbc_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [mtbc_pkg::RAM_W-1:0]   ram_wdata, ram_rdata;

    mtbc_ram #(
        .WIDTH(mtbc_pkg::RAM_W),
        .DEPTH(mtbc_pkg::STACK_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign ram_waddr = count_reg[mtbc_pkg::ADDR_W-1:0];
    assign ram_raddr = ram_waddr - mtbc_pkg::ADDR_W'(2);
    assign ram_wdata = {cmd.entry, cmd.line};

    always_comb begin
        count_next     = count_reg;
        top_entry_next = top_entry_reg;
        top_line_next  = top_line_reg;
        pending_next   = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        if (cmd.clear) begin
            count_next = '0;
        end else if (cmd.push) begin
            ram_we         = 1'b1;
            top_entry_next = cmd.entry;
            top_line_next  = cmd.line;
            count_next     = count_reg + 1'b1;
        end else if (cmd.pop) begin
            // new top comes back from the RAM's registered read port in the following cycle
            count_next   = count_reg - 1'b1;
            ram_re       = (count_reg >= mtbc_pkg::CNT_W'(2));
            pending_next = 1'b1;
        end else if (pending_reg) begin
            top_entry_next = ram_rdata[mtbc_pkg::RAM_W-1:mtbc_pkg::LINE_W];
            top_line_next  = ram_rdata[mtbc_pkg::LINE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pending_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
        end
        top_entry_reg <= top_entry_next;
        top_line_reg  <= top_line_next;
    end

    assign top.empty = (count_reg == '0);
    assign top.full  = (count_reg >= mtbc_pkg::CNT_W'(mtbc_pkg::STACK_DEPTH));
    assign top.entry = pending_reg ? ram_rdata[mtbc_pkg::RAM_W-1:mtbc_pkg::LINE_W]
                                   : top_entry_reg;
    assign top.line  = pending_reg ? ram_rdata[mtbc_pkg::LINE_W-1:0] : top_line_reg;

endmodule

`default_nettype wire

// ----- rtl/mtbc_parser.sv -----
// Tag parser: mode, name and line registers, per-byte next-state logic.
`timescale 1ns / 1ps
`default_nettype none

module mtbc_parser (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_fire,
    input  wire logic [mtbc_pkg::CHAR_W-1:0]  char_code,
    input  wire logic                         end_of_stream,
    input  wire mtbc_pkg::stack_top_t         top,
    output mtbc_pkg::stack_cmd_t              cmd,
    output mtbc_pkg::result_t                 res
);

    mtbc_pkg::mode_t                mode_reg, mode_next;
    logic [mtbc_pkg::NAME_BITS-1:0] name_reg, name_next;
    logic [mtbc_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [mtbc_pkg::LINE_W-1:0]    line_reg, line_next;

    logic [mtbc_pkg::LINE_W-1:0]      line_inc;
    logic [mtbc_pkg::NAME_BITS-1:0]   shifted;
    logic [mtbc_pkg::NAME_BITS-1:0]   add_name;
    logic [mtbc_pkg::LEN_W-1:0]       add_len;
    logic [mtbc_pkg::ENTRY_W-1:0]     packed_name;
    logic                             is_letter, length_ok;
    logic                             do_fail, new_doc;
    logic [mtbc_pkg::STATUS_W-1:0]    fail_st;
    mtbc_pkg::mode_t                  doc_mode;

    assign line_inc = (char_code == mtbc_pkg::CH_LF && line_reg != mtbc_pkg::LINE_MAX)
                      ? line_reg + 1'b1 : line_reg;
    assign is_letter   = (char_code >= mtbc_pkg::CH_A) && (char_code <= mtbc_pkg::CH_Z);
    assign length_ok   = (len_reg != '0) && (len_reg <= mtbc_pkg::LEN_MAX);
    assign packed_name = {len_reg, name_reg};
    // 'A'..'Z' map to 1..26 in the low five bits
    assign shifted     = {name_reg[mtbc_pkg::NAME_BITS-6:0], char_code[4:0]};

    always_comb begin
        if (len_reg < mtbc_pkg::LEN_MAX) begin
            add_name = shifted;
            add_len  = len_reg + 1'b1;
        end else begin
            add_name = name_reg;
            add_len  = mtbc_pkg::LEN_OVER;
        end
    end

    // Next state
    always_comb begin
        mode_next = mode_reg;
        name_next = name_reg;
        len_next  = len_reg;
        line_next = line_reg;
        do_fail   = 1'b0;
        fail_st   = mtbc_pkg::ST_OK;
        new_doc   = 1'b0;
        doc_mode  = mtbc_pkg::MODE_IDLE;
        cmd       = '0;
        cmd.entry = packed_name;
        cmd.line  = line_inc;
        if (in_fire) begin
            if (end_of_stream) begin
                new_doc = 1'b1;
            end else if (mode_reg != mtbc_pkg::MODE_DRAIN) begin
                line_next = line_inc;
                case (mode_reg)
                    mtbc_pkg::MODE_IDLE: begin
                        if (char_code == mtbc_pkg::CH_GT) begin
                            do_fail = 1'b1;
                            fail_st = mtbc_pkg::ST_STRAY;
                        end else if (char_code == mtbc_pkg::CH_LT) begin
                            name_next = '0;
                            len_next  = '0;
                            mode_next = mtbc_pkg::MODE_TAG_START;
                        end
                    end
                    mtbc_pkg::MODE_TAG_START: begin
                        if (char_code == mtbc_pkg::CH_SLASH) begin
                            mode_next = mtbc_pkg::MODE_CLOSE;
                        end else if (char_code == mtbc_pkg::CH_BANG) begin
                            mode_next = mtbc_pkg::MODE_COMMENT;
                        end else if (char_code == mtbc_pkg::CH_GT) begin
                            do_fail = 1'b1;
                            fail_st = mtbc_pkg::ST_LENGTH;
                        end else if (is_letter) begin
                            name_next = add_name;
                            len_next  = add_len;
                            mode_next = mtbc_pkg::MODE_OPEN;
                        end else begin
                            do_fail = 1'b1;
                            fail_st = mtbc_pkg::ST_CHAR;
                        end
                    end
                    mtbc_pkg::MODE_OPEN: begin
                        if (char_code == mtbc_pkg::CH_GT) begin
                            if (!length_ok) begin
                                do_fail = 1'b1;
                                fail_st = mtbc_pkg::ST_LENGTH;
                            end else if (top.full) begin
                                do_fail = 1'b1;
                                fail_st = mtbc_pkg::ST_OVERFLOW;
                            end else begin
                                cmd.push  = 1'b1;
                                name_next = '0;
                                len_next  = '0;
                                mode_next = mtbc_pkg::MODE_IDLE;
                            end
                        end else if (is_letter) begin
                            name_next = add_name;
                            len_next  = add_len;
                        end else begin
                            do_fail = 1'b1;
                            fail_st = mtbc_pkg::ST_CHAR;
                        end
                    end
                    mtbc_pkg::MODE_CLOSE: begin
                        if (char_code == mtbc_pkg::CH_GT) begin
                            if (!length_ok) begin
                                do_fail = 1'b1;
                                fail_st = mtbc_pkg::ST_LENGTH;
                            end else if (top.empty) begin
                                do_fail = 1'b1;
                                fail_st = mtbc_pkg::ST_UNBALANCED;
                            end else if (top.entry != packed_name) begin
                                do_fail = 1'b1;
                                fail_st = mtbc_pkg::ST_UNBALANCED;
                            end else begin
                                cmd.pop   = 1'b1;
                                name_next = '0;
                                len_next  = '0;
                                mode_next = mtbc_pkg::MODE_IDLE;
                            end
                        end else if (is_letter) begin
                            name_next = add_name;
                            len_next  = add_len;
                        end else begin
                            do_fail = 1'b1;
                            fail_st = mtbc_pkg::ST_CHAR;
                        end
                    end
                    mtbc_pkg::MODE_COMMENT: begin
                        if (char_code == mtbc_pkg::CH_GT) begin
                            mode_next = mtbc_pkg::MODE_IDLE;
                        end
                    end
                    default: begin
                        new_doc = 1'b1;
                    end
                endcase
                if (do_fail) begin
                    new_doc  = 1'b1;
                    doc_mode = mtbc_pkg::MODE_DRAIN;
                end
            end
        end
        if (new_doc) begin
            mode_next = doc_mode;
            name_next = '0;
            len_next  = '0;
            line_next = mtbc_pkg::LINE_ONE;
            cmd.clear = 1'b1;
            cmd.push  = 1'b0;
            cmd.pop   = 1'b0;
        end
    end

    // Result
    always_comb begin
        res = '0;
        if (in_fire && mode_reg != mtbc_pkg::MODE_DRAIN) begin
            if (end_of_stream) begin
                res.valid = 1'b1;
                case (mode_reg)
                    mtbc_pkg::MODE_TAG_START, mtbc_pkg::MODE_OPEN,
                    mtbc_pkg::MODE_CLOSE: begin
                        res.status = mtbc_pkg::ST_UNCLOSED;
                        res.line   = line_reg;
                    end
                    mtbc_pkg::MODE_COMMENT: begin
                        res.status = mtbc_pkg::ST_COMMENT;
                        res.line   = line_reg;
                    end
                    default: begin
                        if (!top.empty) begin
                            res.status = mtbc_pkg::ST_UNBALANCED;
                            res.line   = top.line;
                        end
                    end
                endcase
            end else if (do_fail) begin
                res.valid  = 1'b1;
                res.status = fail_st;
                res.line   = line_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= mtbc_pkg::MODE_IDLE;
            name_reg <= '0;
            len_reg  <= '0;
            line_reg <= mtbc_pkg::LINE_ONE;
        end else begin
            mode_reg <= mode_next;
            name_reg <= name_next;
            len_reg  <= len_next;
            line_reg <= line_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mtbc_out_buf.sv -----
// Result register with one skid entry behind it.
`timescale 1ns / 1ps
`default_nettype none

module mtbc_out_buf (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire mtbc_pkg::result_t          res,
    output logic                            in_ready,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [mtbc_pkg::OUT_W-1:0]      m_tdata
);

    localparam int DATA_W = mtbc_pkg::STATUS_W + mtbc_pkg::LINE_W;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [DATA_W-1:0] skid_data_reg, skid_data_next;
    logic [DATA_W-1:0] new_data;

    assign new_data = {res.line, res.status};

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = res.valid;
                out_data_next  = new_data;
            end
        end else if (res.valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = new_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mtbc_pkg::OUT_W - DATA_W){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

// ----- rtl/markup_tag_balance_checker_top.sv -----
// Top level of the markup tag balance checker.
// Streams a document one byte per transfer and checks that <NAME> / </NAME> tags
// (1 to 10 letters A-Z) nest properly, skipping <!...> comments and counting
// lines from 1. A transfer with s_tlast high ends the document (its byte is
// ignored) and yields one status result; the first error inside a document
// yields a result at once, after which bytes are dropped up to the next
// s_tlast, which then yields nothing. Throughput is one transfer per clock
// while s_tready is high: each byte is handled by the parser registers plus
// the top-of-stack register, and the result is registered in the output
// register, or in its skid entry while the sink stalls. The 64-entry tag stack
// lives in a RAM with one write port and one registered read port; on a pop
// the new top is refetched and bypassed from the read data in the following
// cycle. No clearing pass is needed after reset. s_tready drops only when the
// output register and its skid entry both hold results the sink has not taken.
`timescale 1ns / 1ps
`default_nettype none

module markup_tag_balance_checker_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // end_of_stream
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [2:0] status, [26:3] line_number, [31:27] zero
);

    mtbc_pkg::stack_cmd_t stack_cmd;
    mtbc_pkg::stack_top_t stack_top;
    mtbc_pkg::result_t    result;
    logic                 in_fire;

    assign in_fire = s_tvalid && s_tready;

    // byte-level parse and error detection
    mtbc_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .char_code    (s_tdata),
        .end_of_stream(s_tlast),
        .top          (stack_top),
        .cmd          (stack_cmd),
        .res          (result)
    );

    // open-tag stack
    mtbc_stack u_stack (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (stack_cmd),
        .top    (stack_top)
    );

    // result register and skid entry
    mtbc_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .res     (result),
        .in_ready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/mtbc_checker.sv -----
// Port-level checks for the tag balance checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mtbc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // ok carries line zero
    a_ok_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == mtbc_pkg::ST_OK |-> m_tdata[26:3] == 24'd0)
        else $error("ok result with nonzero line");

    // an error always points at a real line
    a_err_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != mtbc_pkg::ST_OK |-> m_tdata[26:3] != 24'd0)
        else $error("error result with line zero");

    // reset empties the output side and opens the input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not empty after reset");

    // input may stall only while a result is held and not taken
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !$past(m_tvalid && m_tready))
        else $error("input stalled without a held result");

endmodule

bind markup_tag_balance_checker_top mtbc_checker u_mtbc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire
